// File: rtl/crr_pkg.sv
// Shared types, constants and helper functions for the color range recolor unit.
`default_nettype none

package crr_pkg;

  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 3;
  localparam int COLOR_W    = CHAN_W * NUM_CHAN;
  localparam int NUM_W      = 2 * CHAN_W;
  localparam int SUM_W      = CHAN_W + 2;
  localparam int RECIP_W    = 11;
  localparam int RECIP_PROD = SUM_W + RECIP_W;

  // floor(x / 3) == (x * 683) >> 11 holds for every x below 2048.
  localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(683);
  localparam int                 AVG_SHIFT = 11;

  localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

  // Divider: one quotient bit per step, several steps per pipeline stage.
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = CHAN_W / DIV_BITS;

  // Blend stages, divider stages and the output register.
  localparam int PIPE_LAT = 4 + DIV_STAGES + 1;

  typedef enum logic [1:0] {
    REG_MID = 2'd0,
    REG_MIN = 2'd1,
    REG_MAX = 2'd2,
    REG_REF = 2'd3
  } cfg_reg_t;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_t;
  typedef logic [NUM_CHAN-1:0][NUM_W-1:0]  num_vec_t;

  typedef struct packed {
    rgb_t              mid_color;
    rgb_t              min_color;
    rgb_t              max_color;
    logic [CHAN_W-1:0] ref_avg;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [CHAN_W-1:0] low;
    logic [CHAN_W-1:0] den;
    logic [CHAN_W-1:0] quot;
  } div_stage_t;

  // Truncated average of the three channels of a packed color.
  function automatic logic [CHAN_W-1:0] avg3(input rgb_t c);
    logic [SUM_W-1:0]      sum;
    logic [RECIP_PROD-1:0] prod;
    sum  = SUM_W'(c[0]) + SUM_W'(c[1]) + SUM_W'(c[2]);
    prod = RECIP_PROD'(sum) * RECIP_PROD'(AVG_RECIP);
    return prod[AVG_SHIFT +: CHAN_W];
  endfunction

  // One restoring division step: shift in the next numerator bit and subtract if it fits.
  function automatic div_stage_t div_step(input div_stage_t x);
    div_stage_t        y;
    logic [CHAN_W:0]   trial;
    trial = {x.rem, x.low[CHAN_W-1]};
    y     = x;
    y.low = {x.low[CHAN_W-2:0], 1'b0};
    if (trial >= {1'b0, x.den}) begin
      y.rem  = CHAN_W'(trial - {1'b0, x.den});
      y.quot = {x.quot[CHAN_W-2:0], 1'b1};
    end else begin
      y.rem  = trial[CHAN_W-1:0];
      y.quot = {x.quot[CHAN_W-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// File: rtl/color_range_recolor_unit.sv
// Top level of the color range recolor unit: configuration registers, datapath and output register.
`default_nettype none

// The unit maps one packed RGB color to a recolored RGB triple. A color is
// taken on in_color at each rising edge where start is high and busy is low.
// busy is high only during reset, so one color may be transferred every cycle.
// Each color yields exactly one result, shown on out_red, out_green and
// out_blue for a single cycle while done is high; the receiver cannot hold it
// off, so results simply stream out in input order.
// From the accepting edge, a color passes through four blend stages (average,
// branch select, products, sum), four divider stages that each resolve two
// quotient bits, and the output register.
// Throughput is one color per cycle; the divider is fully pipelined per channel.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; a transfer writes the register selected by cfg_index. The
// reference color is kept only as its channel average, computed at write time.
// The user must change the registers only while no color is in flight; the unit does not enforce this.
// Synchronous reset clears the registers to zero and drops every item in flight.
module color_range_recolor_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [crr_pkg::COLOR_W-1:0] in_color,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [crr_pkg::COLOR_W-1:0] cfg_data,
  output logic                             done,
  output logic [crr_pkg::CHAN_W-1:0]       out_red,
  output logic [crr_pkg::CHAN_W-1:0]       out_green,
  output logic [crr_pkg::CHAN_W-1:0]       out_blue
);

  crr_pkg::rgb_t                  mid_color;
  crr_pkg::rgb_t                  min_color;
  crr_pkg::rgb_t                  max_color;
  logic [crr_pkg::CHAN_W-1:0]     ref_avg;
  crr_pkg::cfg_t                  cfg;

  logic                           accept;
  logic                           blend_vld;
  crr_pkg::num_vec_t              blend_num;
  logic [crr_pkg::CHAN_W-1:0]     blend_den;
  logic [crr_pkg::NUM_CHAN-1:0]   div_vld;
  crr_pkg::rgb_t                  div_quot;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_color <= '0;
      min_color <= '0;
      max_color <= '0;
      ref_avg   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (crr_pkg::cfg_reg_t'(cfg_index))
        crr_pkg::REG_MID: mid_color <= cfg_data;
        crr_pkg::REG_MIN: min_color <= cfg_data;
        crr_pkg::REG_MAX: max_color <= cfg_data;
        crr_pkg::REG_REF: ref_avg   <= crr_pkg::avg3(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.mid_color = mid_color;
    cfg.min_color = min_color;
    cfg.max_color = max_color;
    cfg.ref_avg   = ref_avg;
  end

  crr_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_color  (in_color),
    .cfg       (cfg),
    .out_valid (blend_vld),
    .num       (blend_num),
    .den       (blend_den)
  );

  // One divider per channel; all three share the divisor.
  for (genvar k = 0; k < crr_pkg::NUM_CHAN; k++) begin : g_div
    crr_div u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (blend_vld),
      .num       (blend_num[k]),
      .den       (blend_den),
      .out_valid (div_vld[k]),
      .quot      (div_quot[k])
    );
  end

  // The blend numerator never exceeds 255 times the divisor, so the 8-bit
  // quotient already is the saturated channel value.
  always_ff @(posedge clk) begin
    out_red   <= div_quot[2];
    out_green <= div_quot[1];
    out_blue  <= div_quot[0];
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= &div_vld;
    end
  end

  // A result only ever comes from a color accepted one latency earlier.
  a_done_from_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, crr_pkg::PIPE_LAT))
    else $error("result strobe without a matching accepted color");

  // The divisor handed to the dividers is never zero.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    blend_vld |-> (blend_den != '0))
    else $error("zero divisor reached the dividers");

  // Each numerator stays below 256 times the divisor so eight quotient bits suffice.
  a_quot_fits: assert property (@(posedge clk) disable iff (rst)
    blend_vld |-> ((blend_num[0] < {blend_den, 8'h00}) &&
                   (blend_num[1] < {blend_den, 8'h00}) &&
                   (blend_num[2] < {blend_den, 8'h00})))
    else $error("blend numerator overflows the quotient width");

  // All three channel dividers stay in lockstep.
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    (div_vld[0] == div_vld[1]) && (div_vld[1] == div_vld[2]))
    else $error("channel dividers out of step");

endmodule

`default_nettype wire

// File: rtl/crr_div.sv
// Pipelined restoring divider producing an 8-bit quotient from a 16-bit numerator.
`default_nettype none

module crr_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic [crr_pkg::NUM_W-1:0]      num,
  input  wire logic [crr_pkg::CHAN_W-1:0]     den,
  output logic                                out_valid,
  output logic [crr_pkg::CHAN_W-1:0]          quot
);

  crr_pkg::div_stage_t                         init;
  crr_pkg::div_stage_t [crr_pkg::DIV_STAGES-1:0] pipe;
  crr_pkg::div_stage_t [crr_pkg::DIV_STAGES-1:0] pipe_next;
  logic [crr_pkg::DIV_STAGES-1:0]              vld;

  // The upper numerator byte is already below the divisor, so eight steps suffice.
  always_comb begin
    init.rem  = num[crr_pkg::NUM_W-1 -: crr_pkg::CHAN_W];
    init.low  = num[crr_pkg::CHAN_W-1:0];
    init.den  = den;
    init.quot = '0;
  end

  always_comb begin
    crr_pkg::div_stage_t cur;
    for (int s = 0; s < crr_pkg::DIV_STAGES; s++) begin
      cur = (s == 0) ? init : pipe[s-1];
      for (int j = 0; j < crr_pkg::DIV_BITS; j++) begin
        cur = crr_pkg::div_step(cur);
      end
      pipe_next[s] = cur;
    end
  end

  always_ff @(posedge clk) begin
    pipe <= pipe_next;
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[crr_pkg::DIV_STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld[crr_pkg::DIV_STAGES-1];
  assign quot      = pipe[crr_pkg::DIV_STAGES-1].quot;

endmodule

`default_nettype wire

// File: rtl/crr_blend.sv
// Averaging, branch selection and blend numerator pipeline for the recolor unit.
`default_nettype none

module crr_blend (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [crr_pkg::COLOR_W-1:0] in_color,
  input  wire crr_pkg::cfg_t               cfg,
  output logic                             out_valid,
  output crr_pkg::num_vec_t                num,
  output logic [crr_pkg::CHAN_W-1:0]       den
);

  // Stage 1: input average.
  logic                        s1_vld;
  logic [crr_pkg::CHAN_W-1:0]  s1_avg;

  // Stage 2: weights, divisor and channel operands.
  logic                        s2_vld;
  logic [crr_pkg::CHAN_W-1:0]  s2_w_mid;
  logic [crr_pkg::CHAN_W-1:0]  s2_w_oth;
  logic [crr_pkg::CHAN_W-1:0]  s2_den;
  crr_pkg::rgb_t               s2_mid;
  crr_pkg::rgb_t               s2_oth;

  // Stage 3: products.
  logic                        s3_vld;
  crr_pkg::num_vec_t           s3_pm;
  crr_pkg::num_vec_t           s3_po;
  logic [crr_pkg::CHAN_W-1:0]  s3_den;

  // Stage 4: numerators.
  logic                        s4_vld;
  crr_pkg::num_vec_t           s4_num;
  logic [crr_pkg::CHAN_W-1:0]  s4_den;

  logic                        use_low;
  logic                        use_none;
  logic [crr_pkg::CHAN_W-1:0]  w_mid_next;
  logic [crr_pkg::CHAN_W-1:0]  w_oth_next;
  logic [crr_pkg::CHAN_W-1:0]  den_next;
  crr_pkg::rgb_t               oth_next;

  always_comb begin
    use_low  = (cfg.ref_avg != '0) && (s1_avg <= cfg.ref_avg);
    use_none = !use_low && (cfg.ref_avg == crr_pkg::CHAN_MAX);
    if (use_low) begin
      w_mid_next = s1_avg;
      w_oth_next = cfg.ref_avg - s1_avg;
      den_next   = cfg.ref_avg;
      oth_next   = cfg.min_color;
    end else if (use_none) begin
      // Zero weights over a unit divisor give a zero result.
      w_mid_next = '0;
      w_oth_next = '0;
      den_next   = crr_pkg::CHAN_W'(1);
      oth_next   = cfg.max_color;
    end else begin
      // Here the average is at or above the reference, so the max weight is avg - ref.
      w_mid_next = crr_pkg::CHAN_MAX - s1_avg;
      w_oth_next = s1_avg - cfg.ref_avg;
      den_next   = crr_pkg::CHAN_MAX - cfg.ref_avg;
      oth_next   = cfg.max_color;
    end
  end

  always_ff @(posedge clk) begin
    s1_avg   <= crr_pkg::avg3(in_color);
    s2_w_mid <= w_mid_next;
    s2_w_oth <= w_oth_next;
    s2_den   <= den_next;
    s2_mid   <= cfg.mid_color;
    s2_oth   <= oth_next;
    for (int k = 0; k < crr_pkg::NUM_CHAN; k++) begin
      s3_pm[k]  <= crr_pkg::NUM_W'(s2_w_mid) * crr_pkg::NUM_W'(s2_mid[k]);
      s3_po[k]  <= crr_pkg::NUM_W'(s2_w_oth) * crr_pkg::NUM_W'(s2_oth[k]);
      s4_num[k] <= s3_pm[k] + s3_po[k];
    end
    s3_den <= s2_den;
    s4_den <= s3_den;
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
    end else begin
      s1_vld <= in_valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
    end
  end

  assign out_valid = s4_vld;
  assign num       = s4_num;
  assign den       = s4_den;

endmodule

`default_nettype wire

// File: verif/tb_color_range_recolor_unit.sv
// Self-checking testbench for the color range recolor unit.
`timescale 1ns / 100ps

module tb_color_range_recolor_unit;
  import crr_pkg::*;

  // One recolored result as it leaves the unit.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } recolor_t;

  // A run is stuck when this many cycles pass with no transfer of any kind.
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PHASES = 9;
  localparam int COLORS_PER_PHASE = 50;

  // Every input is known from time zero; reset starts asserted.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [COLOR_W-1:0] in_color = '0;
  logic               cfg_valid = 1'b0;
  cfg_reg_t           cfg_index = REG_MID;
  logic [COLOR_W-1:0] cfg_data = '0;
  logic               busy;
  logic               cfg_ready;
  logic               done;
  logic [CHAN_W-1:0]  out_red;
  logic [CHAN_W-1:0]  out_green;
  logic [CHAN_W-1:0]  out_blue;

  // Colors waiting to be sent, and recolored results waiting to come back.
  logic [COLOR_W-1:0] colors_to_send[$];
  recolor_t           awaited_recolors[$];

  // The palette as the testbench believes the unit holds it.
  rgb_t mid_rgb = '0;
  rgb_t min_rgb = '0;
  rgb_t max_rgb = '0;
  rgb_t ref_rgb = '0;

  logic color_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   err_count = 0;
  int   quiet_cycles = 0;

  color_range_recolor_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .in_color  (in_color),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

  always #6 clk = ~clk;

  // Truncated mean of the three channels of a packed color.
  function automatic int unsigned channel_avg(rgb_t c);
    return (32'(c[2]) + 32'(c[1]) + 32'(c[0])) / 3;
  endfunction

  // Expected recolor of one input color under the current palette. Colors
  // whose mean is at or below the reference mean blend from the min color
  // toward the mid color; brighter ones blend from the max color toward the
  // mid color. A zero reference mean always takes the bright blend. The dark
  // blend divides by the reference mean, the bright one by its distance from
  // full scale, and each quotient truncates.
  function automatic recolor_t recolor_of(rgb_t color);
    int unsigned in_avg;
    int unsigned key_avg;
    int unsigned span;
    int unsigned headroom;
    int unsigned rest;
    int unsigned blend;
    rgb_t        res;
    recolor_t    rc;
    in_avg  = channel_avg(color);
    key_avg = channel_avg(ref_rgb);
    for (int k = 0; k < NUM_CHAN; k++) begin
      if (key_avg != 0 && in_avg <= key_avg) begin
        blend = (in_avg * mid_rgb[k] + (key_avg - in_avg) * min_rgb[k]) / key_avg;
      end else if (key_avg != 255) begin
        span     = 255 - key_avg;
        headroom = 255 - in_avg;
        rest     = (span >= headroom) ? span - headroom : 0;
        blend    = (headroom * mid_rgb[k] + rest * max_rgb[k]) / span;
      end else begin
        // A reference mean of full scale sends every color down the dark
        // blend, so this arm should stay dead; it yields black if reached.
        blend = 0;
      end
      // Saturation at full scale; the blends never exceed it.
      res[k] = (blend > 255) ? 8'hFF : blend[7:0];
    end
    rc.red   = res[2];
    rc.green = res[1];
    rc.blue  = res[0];
    return rc;
  endfunction

  task automatic check_channel(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // Monitor: everything is sampled at the rising edge, where the unit's own
  // registers have not yet moved. A color transfer queues its prediction; a
  // done cycle retires the oldest prediction. Palette writes update the
  // shadow copy at the edge that completes the write transfer.
  always @(posedge clk) begin
    color_taken <= start && !busy;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MID: mid_rgb = cfg_data;
        REG_MIN: min_rgb = cfg_data;
        REG_MAX: max_rgb = cfg_data;
        REG_REF: ref_rgb = cfg_data;
        default: ;
      endcase
    end
    if (start && !busy) begin
      awaited_recolors.push_back(recolor_of(in_color));
    end
    if (done) begin
      if (awaited_recolors.size() == 0) begin
        $error("result %0d/%0d/%0d arrived with no color in flight",
               out_red, out_green, out_blue);
        err_count++;
      end else begin
        check_channel("out_red", awaited_recolors[0].red, out_red);
        check_channel("out_green", awaited_recolors[0].green, out_green);
        check_channel("out_blue", awaited_recolors[0].blue, out_blue);
        void'(awaited_recolors.pop_front());
      end
    end
  end

  // Driver: changes inputs on the falling edge. The color at the head of the
  // send queue stays on in_color until its transfer is seen, then leaves the
  // queue. Colors go out in bursts of random length; between bursts a random
  // gap is left, and about a third of bursts are followed by no gap at all.
  always @(negedge clk) begin : driver
    logic next_start;
    if (color_taken) begin
      void'(colors_to_send.pop_front());
    end
    next_start = 1'b0;
    if (start && !color_taken) begin
      next_start = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (colors_to_send.size() > 0) begin
      next_start = 1'b1;
      in_color <= colors_to_send[0];
      if (burst_left > 0) begin
        burst_left--;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
    start <= next_start;
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_color_range_recolor_unit: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Writes the whole palette, one register per transfer. valid stays high
  // across back-to-back writes and drops once after the last one.
  task automatic load_palette(logic [COLOR_W-1:0] mid_c, logic [COLOR_W-1:0] min_c,
                              logic [COLOR_W-1:0] max_c, logic [COLOR_W-1:0] key_c);
    cfg_reg_t           idx [4];
    logic [COLOR_W-1:0] val [4];
    idx = '{REG_MID, REG_MIN, REG_MAX, REG_REF};
    val = '{mid_c, min_c, max_c, key_c};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Blocks until every queued color has been sent and every result is back.
  task automatic drain();
    while (colors_to_send.size() != 0 || awaited_recolors.size() != 0) @(posedge clk);
  endtask

  // Reference colors for random phases lean on the corners of the mean:
  // zero, one, just under full scale and full scale.
  function automatic logic [COLOR_W-1:0] pick_reference();
    case ($urandom_range(0, 6))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'h010101;
      3: return 24'hFEFEFE;
      default: return 24'($urandom);
    endcase
  endfunction

  // A random color that is often close to the reference mean, so that the
  // switch between the dark and bright blends is crossed many times.
  function automatic logic [COLOR_W-1:0] pick_color(logic [COLOR_W-1:0] key_c);
    int level;
    case ($urandom_range(0, 3))
      0: begin
        level = int'(channel_avg(key_c)) + int'($urandom_range(0, 6)) - 3;
        level = (level < 0) ? 0 : (level > 255) ? 255 : level;
        return {3{level[7:0]}};
      end
      1: return key_c ^ (24'($urandom_range(0, 7)) << (8 * $urandom_range(0, 2)));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [COLOR_W-1:0] key_c;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: a mid-gray reference gives a mean of 128. Corners of the
    // input, single channels, a mean exactly at the reference, one above,
    // one below, and the darkest and brightest grays.
    load_palette(24'h3C8CDC, 24'h102030, 24'hF0E0D0, 24'h808080);
    colors_to_send = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                       24'h808080, 24'h818080, 24'h818181, 24'h7F7F7F, 24'h010101,
                       24'hFEFEFE, 24'h020000, 24'h030000};
    drain();

    // A black reference has a zero mean: every color takes the bright blend.
    load_palette(24'hA5A5A5, 24'hFFFFFF, 24'h5A5A5A, 24'h000000);
    colors_to_send = '{24'h000000, 24'h010101, 24'hFFFFFF};
    drain();

    // A white reference has a full-scale mean: every color takes the dark blend.
    load_palette(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF);
    colors_to_send = '{24'hFFFFFF, 24'h000000, 24'h7F7F7F};
    drain();

    // Reference mean one below full scale: the bright blend divides by one.
    load_palette(24'h00FF80, 24'hFF0000, 24'h0000FF, 24'hFEFEFE);
    colors_to_send = '{24'hFFFFFF, 24'hFEFEFE, 24'hFDFEFF};
    drain();

    // Reference mean of one: the dark blend divides by one.
    load_palette(24'hFFFFFF, 24'h0080FF, 24'hFF8000, 24'h010101);
    colors_to_send = '{24'h000000, 24'h010101, 24'h020202, 24'h000003};
    drain();

    // Random phases: the first two on fixed extreme palettes, the third with extreme min and max colors.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          key_c = 24'h000000;
          load_palette(24'h000000, 24'h000000, 24'h000000, key_c);
        end
        1: begin
          key_c = 24'hFFFFFF;
          load_palette(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, key_c);
        end
        2: begin
          key_c = 24'($urandom);
          load_palette(24'($urandom), 24'hFFFFFF, 24'h000000, key_c);
        end
        default: begin
          key_c = pick_reference();
          load_palette(24'($urandom), 24'($urandom), 24'($urandom), key_c);
        end
      endcase
      for (int i = 0; i < COLORS_PER_PHASE; i++) begin
        colors_to_send.push_back(pick_color(key_c));
      end
      drain();
    end

    // Let the pipeline empty out fully before the verdict.
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_color_range_recolor_unit: clean");
    end else begin
      $display("tb_color_range_recolor_unit: errors");
    end
    $finish;
  end

endmodule
